// ===== hdl/cpu8_pkg.sv =====
// ----------------------------------------------------------------------------
// cpu8_pkg
// Shared operation codes, flag positions, reset values and the result type
// of the 8-bit accumulator execute core.
// ----------------------------------------------------------------------------
`default_nettype none

package cpu8_pkg;

  // Operation codes
  localparam logic [5:0] OP_ADC   = 6'd0;
  localparam logic [5:0] OP_SBC   = 6'd1;
  localparam logic [5:0] OP_AND   = 6'd2;
  localparam logic [5:0] OP_ORA   = 6'd3;
  localparam logic [5:0] OP_EOR   = 6'd4;
  localparam logic [5:0] OP_CMP   = 6'd5;
  localparam logic [5:0] OP_CPX   = 6'd6;
  localparam logic [5:0] OP_CPY   = 6'd7;
  localparam logic [5:0] OP_BIT   = 6'd8;
  localparam logic [5:0] OP_LDA   = 6'd9;
  localparam logic [5:0] OP_LDX   = 6'd10;
  localparam logic [5:0] OP_LDY   = 6'd11;
  localparam logic [5:0] OP_ASL_M = 6'd12;
  localparam logic [5:0] OP_LSR_M = 6'd13;
  localparam logic [5:0] OP_ROL_M = 6'd14;
  localparam logic [5:0] OP_ROR_M = 6'd15;
  localparam logic [5:0] OP_ASL_A = 6'd16;
  localparam logic [5:0] OP_LSR_A = 6'd17;
  localparam logic [5:0] OP_ROL_A = 6'd18;
  localparam logic [5:0] OP_ROR_A = 6'd19;
  localparam logic [5:0] OP_INC   = 6'd20;
  localparam logic [5:0] OP_DEC   = 6'd21;
  localparam logic [5:0] OP_INX   = 6'd22;
  localparam logic [5:0] OP_INY   = 6'd23;
  localparam logic [5:0] OP_DEX   = 6'd24;
  localparam logic [5:0] OP_DEY   = 6'd25;
  localparam logic [5:0] OP_TAX   = 6'd26;
  localparam logic [5:0] OP_TXA   = 6'd27;
  localparam logic [5:0] OP_TAY   = 6'd28;
  localparam logic [5:0] OP_TYA   = 6'd29;
  localparam logic [5:0] OP_TSX   = 6'd30;
  localparam logic [5:0] OP_TXS   = 6'd31;
  localparam logic [5:0] OP_CLC   = 6'd32;
  localparam logic [5:0] OP_SEC   = 6'd33;
  localparam logic [5:0] OP_CLI   = 6'd34;
  localparam logic [5:0] OP_SEI   = 6'd35;
  localparam logic [5:0] OP_CLV   = 6'd36;
  localparam logic [5:0] OP_CLD   = 6'd37;
  localparam logic [5:0] OP_SED   = 6'd38;
  localparam logic [5:0] OP_STA   = 6'd39;
  localparam logic [5:0] OP_STX   = 6'd40;
  localparam logic [5:0] OP_STY   = 6'd41;
  localparam logic [5:0] OP_PHA   = 6'd42;
  localparam logic [5:0] OP_PHP   = 6'd43;
  localparam logic [5:0] OP_PLA   = 6'd44;
  localparam logic [5:0] OP_PLP   = 6'd45;
  localparam logic [5:0] OP_NOP   = 6'd46;

  // Status bit positions
  localparam int unsigned FLAG_C = 0;
  localparam int unsigned FLAG_Z = 1;
  localparam int unsigned FLAG_I = 2;
  localparam int unsigned FLAG_D = 3;
  localparam int unsigned FLAG_B = 4;
  localparam int unsigned FLAG_U = 5;
  localparam int unsigned FLAG_V = 6;
  localparam int unsigned FLAG_N = 7;

  // Reset values
  localparam logic [7:0] SP_RESET     = 8'hFD;
  localparam logic [7:0] STATUS_RESET = 8'h24;

  // One result request
  typedef struct packed {
    logic [7:0] acc_value;
    logic [7:0] x_value;
    logic [7:0] y_value;
    logic [7:0] stack_value;
    logic [7:0] status_value;
    logic       write_enable;
    logic [7:0] write_data;
    logic       write_to_stack;
    logic [7:0] stack_slot;
  } result_t;

endpackage

`default_nettype wire

// ===== hdl/cpu8_alu_register_execute_core.sv =====
// ----------------------------------------------------------------------------
// cpu8_alu_register_execute_core
// A, X, Y, stack pointer and status with the ALU of an 8-bit accumulator
// processor; one operation and its operand byte in, one register/write report
// out.
// ----------------------------------------------------------------------------
// The core takes one operation per clock while in_stall is low and registers
// its result. The whole operation is a single 8-bit ALU pass from the register
// file to the result register, and the registers update at the accepting
// edge, so dependent operations follow back to back. Results leave through a
// two-entry output buffer: a request is accepted while one result waits to be
// taken, and in_stall rises only when both entries are full. Reset leaves
// A = X = Y = 0, stack pointer 0xFD and status 0x24. Pulls expect the operand
// to be the byte at stack slot sp+1; add and subtract are binary only.
`default_nettype none

module cpu8_alu_register_execute_core (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [5:0] in_operation,
  input  wire logic [7:0] in_operand,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_acc_value,
  output logic [7:0]      out_x_value,
  output logic [7:0]      out_y_value,
  output logic [7:0]      out_stack_value,
  output logic [7:0]      out_status_value,
  output logic            out_write_enable,
  output logic [7:0]      out_write_data,
  output logic            out_write_to_stack,
  output logic [7:0]      out_stack_slot
);

  // Architectural registers
  logic [7:0] acc_r, x_r, y_r, sp_r, status_r;
  logic [7:0] acc_nxt, x_nxt, y_nxt, sp_nxt, status_nxt;

  // Output buffer
  logic               out_valid_r, skid_valid_r;
  cpu8_pkg::result_t  out_data_r, skid_data_r;
  cpu8_pkg::result_t  res;

  logic accept, take;

  // ALU datapath
  logic [7:0] add_b;
  logic [8:0] sum9;
  logic       add_ovf;
  logic [7:0] cmp_reg;
  logic [8:0] cmp_diff;
  logic [7:0] sh_src, sh_res;
  logic       sh_cout;
  logic [7:0] nz_val;
  logic       nz_upd;
  logic       we, to_stack;
  logic [7:0] wdata, slot;

  assign accept = in_valid && !in_stall;
  assign take   = out_valid_r && !out_stall;

  // Add with carry; subtract adds the inverted operand
  assign add_b   = (in_operation == cpu8_pkg::OP_SBC) ? ~in_operand : in_operand;
  assign sum9    = {1'b0, acc_r} + {1'b0, add_b} + {8'h00, status_r[cpu8_pkg::FLAG_C]};
  assign add_ovf = ~(acc_r[7] ^ add_b[7]) & (acc_r[7] ^ sum9[7]);

  // Compare against A, X or Y
  always_comb begin
    case (in_operation)
      cpu8_pkg::OP_CPX: cmp_reg = x_r;
      cpu8_pkg::OP_CPY: cmp_reg = y_r;
      default:          cmp_reg = acc_r;
    endcase
  end
  assign cmp_diff = {1'b0, cmp_reg} - {1'b0, in_operand};

  // Shift and rotate: low two code bits pick the kind, bit 4 picks A
  assign sh_src = in_operation[4] ? acc_r : in_operand;
  always_comb begin
    case (in_operation[1:0])
      2'd0: begin
        sh_res  = {sh_src[6:0], 1'b0};
        sh_cout = sh_src[7];
      end
      2'd1: begin
        sh_res  = {1'b0, sh_src[7:1]};
        sh_cout = sh_src[0];
      end
      2'd2: begin
        sh_res  = {sh_src[6:0], status_r[cpu8_pkg::FLAG_C]};
        sh_cout = sh_src[7];
      end
      default: begin
        sh_res  = {status_r[cpu8_pkg::FLAG_C], sh_src[7:1]};
        sh_cout = sh_src[0];
      end
    endcase
  end

  // Decode the operation and form the next register values
  always_comb begin
    acc_nxt    = acc_r;
    x_nxt      = x_r;
    y_nxt      = y_r;
    sp_nxt     = sp_r;
    status_nxt = status_r;
    nz_val     = 8'h00;
    nz_upd     = 1'b0;
    we         = 1'b0;
    to_stack   = 1'b0;
    wdata      = 8'h00;
    slot       = 8'h00;
    case (in_operation)
      cpu8_pkg::OP_ADC, cpu8_pkg::OP_SBC: begin
        acc_nxt                       = sum9[7:0];
        status_nxt[cpu8_pkg::FLAG_V] = add_ovf;
        status_nxt[cpu8_pkg::FLAG_C] = sum9[8];
        nz_val = sum9[7:0];
        nz_upd = 1'b1;
      end
      cpu8_pkg::OP_AND: begin
        acc_nxt = acc_r & in_operand;
        nz_val  = acc_r & in_operand;
        nz_upd  = 1'b1;
      end
      cpu8_pkg::OP_ORA: begin
        acc_nxt = acc_r | in_operand;
        nz_val  = acc_r | in_operand;
        nz_upd  = 1'b1;
      end
      cpu8_pkg::OP_EOR: begin
        acc_nxt = acc_r ^ in_operand;
        nz_val  = acc_r ^ in_operand;
        nz_upd  = 1'b1;
      end
      cpu8_pkg::OP_CMP, cpu8_pkg::OP_CPX, cpu8_pkg::OP_CPY: begin
        status_nxt[cpu8_pkg::FLAG_C] = ~cmp_diff[8];
        nz_val = cmp_diff[7:0];
        nz_upd = 1'b1;
      end
      cpu8_pkg::OP_BIT: begin
        status_nxt[cpu8_pkg::FLAG_N] = in_operand[7];
        status_nxt[cpu8_pkg::FLAG_V] = in_operand[6];
        status_nxt[cpu8_pkg::FLAG_Z] = ((in_operand & acc_r) == 8'h00);
      end
      cpu8_pkg::OP_LDA, cpu8_pkg::OP_PLA: begin
        acc_nxt = in_operand;
        nz_val  = in_operand;
        nz_upd  = 1'b1;
        if (in_operation == cpu8_pkg::OP_PLA) begin
          sp_nxt = sp_r + 8'd1;
        end
      end
      cpu8_pkg::OP_LDX: begin
        x_nxt  = in_operand;
        nz_val = in_operand;
        nz_upd = 1'b1;
      end
      cpu8_pkg::OP_LDY: begin
        y_nxt  = in_operand;
        nz_val = in_operand;
        nz_upd = 1'b1;
      end
      cpu8_pkg::OP_ASL_M, cpu8_pkg::OP_LSR_M,
      cpu8_pkg::OP_ROL_M, cpu8_pkg::OP_ROR_M: begin
        status_nxt[cpu8_pkg::FLAG_C] = sh_cout;
        nz_val = sh_res;
        nz_upd = 1'b1;
        we     = 1'b1;
        wdata  = sh_res;
      end
      cpu8_pkg::OP_ASL_A, cpu8_pkg::OP_LSR_A,
      cpu8_pkg::OP_ROL_A, cpu8_pkg::OP_ROR_A: begin
        status_nxt[cpu8_pkg::FLAG_C] = sh_cout;
        acc_nxt = sh_res;
        nz_val  = sh_res;
        nz_upd  = 1'b1;
      end
      cpu8_pkg::OP_INC: begin
        nz_val = in_operand + 8'd1;
        nz_upd = 1'b1;
        we     = 1'b1;
        wdata  = in_operand + 8'd1;
      end
      cpu8_pkg::OP_DEC: begin
        nz_val = in_operand - 8'd1;
        nz_upd = 1'b1;
        we     = 1'b1;
        wdata  = in_operand - 8'd1;
      end
      cpu8_pkg::OP_INX: begin
        x_nxt  = x_r + 8'd1;
        nz_val = x_r + 8'd1;
        nz_upd = 1'b1;
      end
      cpu8_pkg::OP_INY: begin
        y_nxt  = y_r + 8'd1;
        nz_val = y_r + 8'd1;
        nz_upd = 1'b1;
      end
      cpu8_pkg::OP_DEX: begin
        x_nxt  = x_r - 8'd1;
        nz_val = x_r - 8'd1;
        nz_upd = 1'b1;
      end
      cpu8_pkg::OP_DEY: begin
        y_nxt  = y_r - 8'd1;
        nz_val = y_r - 8'd1;
        nz_upd = 1'b1;
      end
      cpu8_pkg::OP_TAX: begin
        x_nxt  = acc_r;
        nz_val = acc_r;
        nz_upd = 1'b1;
      end
      cpu8_pkg::OP_TXA: begin
        acc_nxt = x_r;
        nz_val  = x_r;
        nz_upd  = 1'b1;
      end
      cpu8_pkg::OP_TAY: begin
        y_nxt  = acc_r;
        nz_val = acc_r;
        nz_upd = 1'b1;
      end
      cpu8_pkg::OP_TYA: begin
        acc_nxt = y_r;
        nz_val  = y_r;
        nz_upd  = 1'b1;
      end
      cpu8_pkg::OP_TSX: begin
        x_nxt  = sp_r;
        nz_val = sp_r;
        nz_upd = 1'b1;
      end
      cpu8_pkg::OP_TXS: sp_nxt = x_r;
      cpu8_pkg::OP_CLC: status_nxt[cpu8_pkg::FLAG_C] = 1'b0;
      cpu8_pkg::OP_SEC: status_nxt[cpu8_pkg::FLAG_C] = 1'b1;
      cpu8_pkg::OP_CLI: status_nxt[cpu8_pkg::FLAG_I] = 1'b0;
      cpu8_pkg::OP_SEI: status_nxt[cpu8_pkg::FLAG_I] = 1'b1;
      cpu8_pkg::OP_CLV: status_nxt[cpu8_pkg::FLAG_V] = 1'b0;
      cpu8_pkg::OP_CLD: status_nxt[cpu8_pkg::FLAG_D] = 1'b0;
      cpu8_pkg::OP_SED: status_nxt[cpu8_pkg::FLAG_D] = 1'b1;
      cpu8_pkg::OP_STA: begin
        we    = 1'b1;
        wdata = acc_r;
      end
      cpu8_pkg::OP_STX: begin
        we    = 1'b1;
        wdata = x_r;
      end
      cpu8_pkg::OP_STY: begin
        we    = 1'b1;
        wdata = y_r;
      end
      cpu8_pkg::OP_PHA: begin
        we       = 1'b1;
        wdata    = acc_r;
        to_stack = 1'b1;
        slot     = sp_r;
        sp_nxt   = sp_r - 8'd1;
      end
      cpu8_pkg::OP_PHP: begin
        we       = 1'b1;
        wdata    = status_r;
        wdata[cpu8_pkg::FLAG_U] = 1'b1;
        wdata[cpu8_pkg::FLAG_B] = 1'b1;
        to_stack = 1'b1;
        slot     = sp_r;
        sp_nxt   = sp_r - 8'd1;
      end
      cpu8_pkg::OP_PLP: begin
        sp_nxt     = sp_r + 8'd1;
        status_nxt = in_operand;
        status_nxt[cpu8_pkg::FLAG_B] = 1'b0;
        status_nxt[cpu8_pkg::FLAG_U] = 1'b1;
      end
      default: ;
    endcase
    // Common N and Z update
    if (nz_upd) begin
      status_nxt[cpu8_pkg::FLAG_N] = nz_val[7];
      status_nxt[cpu8_pkg::FLAG_Z] = (nz_val == 8'h00);
    end
  end

  // Pack the result request
  always_comb begin
    res.acc_value      = acc_nxt;
    res.x_value        = x_nxt;
    res.y_value        = y_nxt;
    res.stack_value    = sp_nxt;
    res.status_value   = status_nxt;
    res.write_enable   = we;
    res.write_data     = wdata;
    res.write_to_stack = to_stack;
    res.stack_slot     = slot;
  end

  // Advance the register file on each accepted request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r    <= 8'h00;
      x_r      <= 8'h00;
      y_r      <= 8'h00;
      sp_r     <= cpu8_pkg::SP_RESET;
      status_r <= cpu8_pkg::STATUS_RESET;
    end else if (accept) begin
      acc_r    <= acc_nxt;
      x_r      <= x_nxt;
      y_r      <= y_nxt;
      sp_r     <= sp_nxt;
      status_r <= status_nxt;
    end
  end

  // Output buffer control: main entry plus one skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (accept) begin
      if (!out_valid_r || take) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (take) begin
      if (skid_valid_r) begin
        skid_valid_r <= 1'b0;
      end else begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Output buffer payload
  always_ff @(posedge clk) begin
    if (accept) begin
      if (!out_valid_r || take) begin
        out_data_r <= res;
      end else begin
        skid_data_r <= res;
      end
    end else if (take && skid_valid_r) begin
      out_data_r <= skid_data_r;
    end
  end

  assign in_stall           = skid_valid_r;
  assign out_valid          = out_valid_r;
  assign out_acc_value      = out_data_r.acc_value;
  assign out_x_value        = out_data_r.x_value;
  assign out_y_value        = out_data_r.y_value;
  assign out_stack_value    = out_data_r.stack_value;
  assign out_status_value   = out_data_r.status_value;
  assign out_write_enable   = out_data_r.write_enable;
  assign out_write_data     = out_data_r.write_data;
  assign out_write_to_stack = out_data_r.write_to_stack;
  assign out_stack_slot     = out_data_r.stack_slot;

endmodule

`default_nettype wire

// ===== hdl/cpu8_checker.sv =====
// ----------------------------------------------------------------------------
// cpu8_checker
// Port-level checks on the execute core's result stream, bound to the top
// level.
// ----------------------------------------------------------------------------
`default_nettype none

module cpu8_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [7:0] out_acc_value,
  input wire logic [7:0] out_status_value,
  input wire logic       out_write_enable,
  input wire logic [7:0] out_write_data,
  input wire logic       out_write_to_stack,
  input wire logic [7:0] out_stack_slot
);

  // Hold a stalled result request
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=>
      (out_valid && $stable(out_acc_value) && $stable(out_status_value)))
    else $error("stalled result changed");

  // Unused write fields read as zero when nothing is written
  a_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_write_enable) |->
      (out_write_data == 8'h00 && !out_write_to_stack && out_stack_slot == 8'h00))
    else $error("write fields set without a write");

  // Slot is only named for a stack write
  a_slot: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_write_to_stack) |-> (out_stack_slot == 8'h00))
    else $error("stack slot set for an effective-address write");

  // Fixed status bits: unused bit set, break bit never stored
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status_value[cpu8_pkg::FLAG_U] &&
                   !out_status_value[cpu8_pkg::FLAG_B]))
    else $error("fixed status bits wrong");

endmodule

bind cpu8_alu_register_execute_core cpu8_checker u_cpu8_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_acc_value      (out_acc_value),
  .out_status_value   (out_status_value),
  .out_write_enable   (out_write_enable),
  .out_write_data     (out_write_data),
  .out_write_to_stack (out_write_to_stack),
  .out_stack_slot     (out_stack_slot)
);

`default_nettype wire
